@@ design/bf8q_pkg.sv @@
// bf8q_pkg: shared widths and fp32 / e4m3 constants for the bf16 to fp8 quantiser
// depends on nothing
`timescale 1ns / 1ps
package bf8q_pkg;

  localparam int BF16_W = 16;
  localparam int FP32_W = 32;
  localparam int FP8_W  = 8;

  // reset amax (1.0) and the scale derived from it (448.0)
  localparam logic [31:0] AMAX_RESET  = 32'h3F80_0000;
  localparam logic [31:0] SCALE_RESET = 32'h43E0_0000;

  // epsilon 1e-8 as fp32: biased exponent and stored mantissa
  localparam logic [31:0] EPS_BITS = 32'h322B_CC77;
  localparam logic [7:0]  EPS_EXP  = 8'd100;
  localparam logic [22:0] EPS_MANT = 23'h2B_CC77;

  // 448.0 significand with hidden bit, biased exponent of 448 is 135
  localparam logic [23:0] LIMIT_SIG = 24'hE0_0000;

  // fp32 special patterns
  localparam logic [31:0] FP32_QNAN    = 32'h7FC0_0000;
  localparam logic [31:0] FP32_POS_INF = 32'h7F80_0000;

  // largest finite e4m3 magnitude code (448)
  localparam logic [6:0] E4M3_MAX_MAG = 7'h7E;

endpackage

@@ design/bf8q_conv.sv @@
// bf8q_conv: one bf16 value times the fp32 scale, rounded to fp32, clamped and
// rounded into an e4m3 byte; purely combinational
// depends on bf8q_pkg
`timescale 1ns / 1ps
module bf8q_conv (
  input  logic [bf8q_pkg::BF16_W-1:0] value_bf16,
  input  logic [bf8q_pkg::FP32_W-1:0] scale_bits,
  output logic [bf8q_pkg::FP8_W-1:0]  value_fp8
);

  logic        v_s, s_s, sgn;
  logic [7:0]  v_e, s_e;
  logic [6:0]  v_m;
  logic [22:0] s_m;
  logic        v_nan, v_inf, v_small, v_exact0, s_nan, s_inf, s_zero;
  logic [31:0] prod, prod_n;
  logic        p_g, p_st, p_inc;
  logic [24:0] p_rnd;
  logic [22:0] p_mant;
  logic signed [10:0] e_un;
  logic [7:0]  eb;
  logic [3:0]  n_exp;
  logic [19:0] n_rem;
  logic [7:0]  n_code;
  logic        n_inc;
  logic [47:0] sub_t;
  logic        sub_inc;
  logic [7:0]  sub_code;
  logic [4:0]  sub_sh;
  logic [7:0]  mag_code;
  logic [6:0]  mag;

  // field split and operand classes
  assign v_s      = value_bf16[15];
  assign v_e      = value_bf16[14:7];
  assign v_m      = value_bf16[6:0];
  assign s_s      = scale_bits[31];
  assign s_e      = scale_bits[30:23];
  assign s_m      = scale_bits[22:0];
  assign sgn      = v_s ^ s_s;
  assign v_nan    = (v_e == 8'hFF) && (v_m != 7'd0);
  assign v_inf    = (v_e == 8'hFF) && (v_m == 7'd0);
  assign v_small  = (v_e == 8'd0);
  assign v_exact0 = v_small && (v_m == 7'd0);
  assign s_nan    = (s_e == 8'hFF) && (s_m != 23'd0);
  assign s_inf    = (s_e == 8'hFF) && (s_m == 23'd0);
  assign s_zero   = (s_e == 8'd0);

  // significand product and fp32 rounding
  assign prod   = {24'd0, 1'b1, v_m} * {8'd0, 1'b1, s_m};
  assign prod_n = prod[31] ? prod : {prod[30:0], 1'b0};
  assign p_g    = prod_n[7];
  assign p_st   = |prod_n[6:0];
  assign p_inc  = p_g & (p_st | prod_n[8]);
  assign p_rnd  = {1'b0, prod_n[31:8]} + {24'd0, p_inc};
  assign p_mant = p_rnd[24] ? 23'd0 : p_rnd[22:0];
  assign e_un   = $signed({3'b000, v_e}) + $signed({3'b000, s_e}) - 11'sd254
                  + $signed({10'd0, prod[31]}) + $signed({10'd0, p_rnd[24]});
  assign eb     = 8'(e_un + 11'sd127);

  // normal e4m3 range
  assign n_exp  = 4'(eb - 8'd120);
  assign n_rem  = p_mant[19:0];
  assign n_inc  = (n_rem > 20'h80000) || ((n_rem == 20'h80000) && p_mant[20]);
  assign n_code = {1'b0, n_exp, p_mant[22:20]} + {7'd0, n_inc};

  // subnormal e4m3 range, shift of 21 to 24
  assign sub_sh   = 5'(8'd141 - eb);
  assign sub_t    = {1'b1, p_mant, 24'd0} >> sub_sh;
  assign sub_inc  = sub_t[23] & ((|sub_t[22:0]) | sub_t[24]);
  assign sub_code = sub_t[31:24] + {7'd0, sub_inc};

  // magnitude code for a finite product
  always_comb begin
    priority if (e_un >= 11'sd9) begin
      mag_code = {1'b0, bf8q_pkg::E4M3_MAX_MAG};
    end else if (e_un < -11'sd10) begin
      mag_code = 8'd0;
    end else if (eb >= 8'd121) begin
      mag_code = (n_code > {1'b0, bf8q_pkg::E4M3_MAX_MAG}) ?
                 {1'b0, bf8q_pkg::E4M3_MAX_MAG} : n_code;
    end else begin
      mag_code = sub_code;
    end
  end
  assign mag = mag_code[6:0];

  // special operands first, nan goes to +448
  always_comb begin
    priority if (v_nan || s_nan) begin
      value_fp8 = {1'b0, bf8q_pkg::E4M3_MAX_MAG};
    end else if (v_inf) begin
      value_fp8 = s_zero ? {1'b0, bf8q_pkg::E4M3_MAX_MAG} : {sgn, bf8q_pkg::E4M3_MAX_MAG};
    end else if (s_inf) begin
      value_fp8 = v_exact0 ? {1'b0, bf8q_pkg::E4M3_MAX_MAG} : {sgn, bf8q_pkg::E4M3_MAX_MAG};
    end else if (v_small || s_zero) begin
      value_fp8 = {sgn, 7'd0};
    end else begin
      value_fp8 = {sgn, mag};
    end
  end

endmodule

@@ design/bf8q_scale.sv @@
// bf8q_scale: holds the fp32 scale and rederives it as 448 / (amax + 1e-8)
// after each amax write; multi-cycle adder then restoring divider
// depends on bf8q_pkg
`timescale 1ns / 1ps
module bf8q_scale (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        wr_en,
  input  logic [bf8q_pkg::FP32_W-1:0] wr_data,
  output logic [bf8q_pkg::FP32_W-1:0] scale,
  output logic                        busy
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_ADD  = 3'd1;
  localparam logic [2:0] ST_NORM = 3'd2;
  localparam logic [2:0] ST_RND  = 3'd3;
  localparam logic [2:0] ST_PREP = 3'd4;
  localparam logic [2:0] ST_DIV  = 3'd5;
  localparam logic [2:0] ST_QRND = 3'd6;
  localparam int DIV_STEPS = 26;
  localparam logic [4:0] DIV_LAST = 5'(DIV_STEPS - 1);

  logic [2:0]  state_r, state_nxt;
  logic [31:0] amax_r, amax_nxt;
  logic [31:0] scale_r, scale_nxt;
  logic [27:0] sum_r, sum_nxt;
  logic [8:0]  exp_r, exp_nxt;
  logic        sgn_r, sgn_nxt;
  logic [23:0] den_sig_r, den_sig_nxt;
  logic [7:0]  den_exp_r, den_exp_nxt;
  logic [24:0] rem_r, rem_nxt;
  logic [25:0] quo_r, quo_nxt;
  logic [8:0]  qexp_r, qexp_nxt;
  logic [4:0]  cnt_r, cnt_nxt;

  // aligned add of amax and epsilon
  logic        a_s, a_big;
  logic [7:0]  a_e, e_big, e_small, d;
  logic [22:0] a_m;
  logic [26:0] big_sig, small_sig, sh, aligned;
  logic        lost;
  logic [27:0] add_sum;

  assign a_s = amax_r[31];
  assign a_e = amax_r[30:23];
  assign a_m = amax_r[22:0];
  assign a_big     = amax_r[30:0] >= bf8q_pkg::EPS_BITS[30:0];
  assign big_sig   = a_big ? {1'b1, a_m, 3'b000} : {1'b1, bf8q_pkg::EPS_MANT, 3'b000};
  assign small_sig = a_big ? {1'b1, bf8q_pkg::EPS_MANT, 3'b000} : {1'b1, a_m, 3'b000};
  assign e_big     = a_big ? a_e : bf8q_pkg::EPS_EXP;
  assign e_small   = a_big ? bf8q_pkg::EPS_EXP : a_e;
  assign d         = e_big - e_small;
  assign sh        = (d >= 8'd27) ? 27'd0 : (small_sig >> d);
  assign lost      = (d >= 8'd27) ? 1'b1 : |(small_sig & ~({27{1'b1}} << d));
  assign aligned   = {sh[26:1], sh[0] | lost};
  assign add_sum   = a_s ? ({1'b0, big_sig} - {1'b0, aligned})
                         : ({1'b0, big_sig} + {1'b0, aligned});

  // rounding of the sum and of the quotient
  logic        s_inc, q_inc;
  logic [24:0] s_rnd, q_rnd;
  assign s_inc = sum_r[2] & ((|sum_r[1:0]) | sum_r[3]);
  assign s_rnd = {1'b0, sum_r[26:3]} + {24'd0, s_inc};
  assign q_inc = quo_r[1] & (quo_r[0] | (rem_r != 25'd0) | quo_r[2]);
  assign q_rnd = {1'b0, quo_r[25:2]} + {24'd0, q_inc};

  // one restoring divide step
  logic        div_ge, prep_lt;
  logic [24:0] div_diff, div_rem;
  assign div_ge   = rem_r >= {1'b0, den_sig_r};
  assign div_diff = rem_r - {1'b0, den_sig_r};
  assign div_rem  = div_ge ? div_diff : rem_r;
  assign prep_lt  = bf8q_pkg::LIMIT_SIG < den_sig_r;

  always_comb begin
    state_nxt   = state_r;
    amax_nxt    = amax_r;
    scale_nxt   = scale_r;
    sum_nxt     = sum_r;
    exp_nxt     = exp_r;
    sgn_nxt     = sgn_r;
    den_sig_nxt = den_sig_r;
    den_exp_nxt = den_exp_r;
    rem_nxt     = rem_r;
    quo_nxt     = quo_r;
    qexp_nxt    = qexp_r;
    cnt_nxt     = cnt_r;
    unique case (state_r)
      ST_IDLE: begin
        if (wr_en) begin
          amax_nxt  = wr_data;
          state_nxt = ST_ADD;
        end
      end
      ST_ADD: begin
        priority if (a_e == 8'hFF && a_m != 23'd0) begin
          scale_nxt = bf8q_pkg::FP32_QNAN;
          state_nxt = ST_IDLE;
        end else if (a_e == 8'hFF) begin
          scale_nxt = {a_s, 31'd0};
          state_nxt = ST_IDLE;
        end else if (a_e == 8'd0) begin
          // zero or subnormal amax vanishes against epsilon
          sgn_nxt     = 1'b0;
          den_sig_nxt = {1'b1, bf8q_pkg::EPS_MANT};
          den_exp_nxt = bf8q_pkg::EPS_EXP;
          state_nxt   = ST_PREP;
        end else begin
          sum_nxt   = add_sum;
          exp_nxt   = {1'b0, e_big};
          sgn_nxt   = a_big & a_s;
          state_nxt = ST_NORM;
        end
      end
      ST_NORM: begin
        priority if (sum_r == 28'd0) begin
          scale_nxt = bf8q_pkg::FP32_POS_INF;
          state_nxt = ST_IDLE;
        end else if (sum_r[27]) begin
          sum_nxt   = {1'b0, sum_r[27:2], sum_r[1] | sum_r[0]};
          exp_nxt   = exp_r + 9'd1;
          state_nxt = ST_RND;
        end else if (!sum_r[26]) begin
          sum_nxt = {sum_r[26:0], 1'b0};
          exp_nxt = exp_r - 9'd1;
        end else begin
          state_nxt = ST_RND;
        end
      end
      ST_RND: begin
        den_sig_nxt = s_rnd[24] ? 24'h80_0000 : s_rnd[23:0];
        den_exp_nxt = 8'(exp_r + {8'd0, s_rnd[24]});
        state_nxt   = ST_PREP;
      end
      ST_PREP: begin
        rem_nxt   = prep_lt ? {bf8q_pkg::LIMIT_SIG, 1'b0} : {1'b0, bf8q_pkg::LIMIT_SIG};
        qexp_nxt  = 9'd262 - {1'b0, den_exp_r} - {8'd0, prep_lt};
        quo_nxt   = 26'd0;
        cnt_nxt   = 5'd0;
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        rem_nxt = {div_rem[23:0], 1'b0};
        quo_nxt = {quo_r[24:0], div_ge};
        cnt_nxt = cnt_r + 5'd1;
        if (cnt_r == DIV_LAST) begin
          state_nxt = ST_QRND;
        end
      end
      ST_QRND: begin
        scale_nxt = {sgn_r, 8'(qexp_r + {8'd0, q_rnd[24]}),
                     q_rnd[24] ? 23'd0 : q_rnd[22:0]};
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control and scale with reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      scale_r <= bf8q_pkg::SCALE_RESET;
      amax_r  <= bf8q_pkg::AMAX_RESET;
    end else begin
      state_r <= state_nxt;
      scale_r <= scale_nxt;
      amax_r  <= amax_nxt;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    sum_r     <= sum_nxt;
    exp_r     <= exp_nxt;
    sgn_r     <= sgn_nxt;
    den_sig_r <= den_sig_nxt;
    den_exp_r <= den_exp_nxt;
    rem_r     <= rem_nxt;
    quo_r     <= quo_nxt;
    qexp_r    <= qexp_nxt;
    cnt_r     <= cnt_nxt;
  end

  assign scale = scale_r;
  assign busy  = (state_r != ST_IDLE);

endmodule

@@ design/bf16_to_fp8_e4m3_scaled_quantize_top.sv @@
// bf16_to_fp8_e4m3_scaled_quantize_top: stream quantiser, bf16 in, e4m3 byte out
// depends on bf8q_pkg, bf8q_scale, bf8q_conv
`timescale 1ns / 1ps
// Each bf16 item is multiplied by the stored fp32 scale, clamped to +/-448 and
// rounded into an OCP e4m3 byte; one item per cycle is taken while in_stall
// is low, and each item passes the input register, then the result register.
// A NaN product gives +448. A cfg_wr_data write taken while the scale is not
// busy sets amax, and the scale 448 / (amax + 1e-8) is rederived by a
// bit-serial divider; in_stall is high while it is rederived. Reset loads amax
// 1.0 and scale 448 with no wait.
module bf16_to_fp8_e4m3_scaled_quantize_top (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [bf8q_pkg::BF16_W-1:0] in_value_bf16,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [bf8q_pkg::FP8_W-1:0]  out_value_fp8,
  input  logic                        cfg_wr_en,
  input  logic [bf8q_pkg::FP32_W-1:0] cfg_wr_data
);

  logic                        busy;
  logic [bf8q_pkg::FP32_W-1:0] scale;
  logic                        s1_valid_r, s1_valid_nxt;
  logic [bf8q_pkg::BF16_W-1:0] s1_value_r;
  logic                        out_valid_r, out_valid_nxt;
  logic [bf8q_pkg::FP8_W-1:0]  out_value_r;
  logic [bf8q_pkg::FP8_W-1:0]  conv_byte;
  logic                        s2_adv, s1_adv, accept;

  // scale register and its derivation
  bf8q_scale u_scale (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (cfg_wr_en),
    .wr_data (cfg_wr_data),
    .scale   (scale),
    .busy    (busy)
  );

  // quantise the registered item
  bf8q_conv u_conv (
    .value_bf16 (s1_value_r),
    .scale_bits (scale),
    .value_fp8  (conv_byte)
  );

  // pipeline flow control
  assign s2_adv   = !out_valid_r || !out_stall;
  assign s1_adv   = !s1_valid_r || s2_adv;
  assign in_stall = busy || !s1_adv;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    s1_valid_nxt  = s1_valid_r;
    out_valid_nxt = out_valid_r;
    if (s1_adv) begin
      s1_valid_nxt = accept;
    end
    if (s2_adv) begin
      out_valid_nxt = s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // item payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_value_r <= in_value_bf16;
    end
    if (s2_adv && s1_valid_r) begin
      out_value_r <= conv_byte;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_value_fp8 = out_value_r;

endmodule
